FILE: hdl/scoped_unit_allocator_top_defines.svh
// Assertion macros used by the allocator datapath.
`ifndef SCOPED_UNIT_ALLOCATOR_TOP_DEFINES_SVH
`define SCOPED_UNIT_ALLOCATOR_TOP_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define SUA_ASSERT_NOW(label, clk, rst_n, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
		else $error("allocator check failed");

// The condition must hold in the cycle after the trigger.
`define SUA_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error("allocator check failed");

`endif

FILE: hdl/sua_pkg.sv
`timescale 1ns / 1ps

package sua_pkg;

	localparam int MAP_BITS        = 32;
	localparam int MAX_UNITS_DEF   = 32;
	localparam int MAX_LAYERS_DEF  = 16;
	localparam int OP_W            = 3;
	localparam int SLOT_W          = 4;
	localparam int UNIT_W          = 5;
	localparam int CFG_W           = 6;
	localparam int APB_DATA_W      = 32;
	localparam int APB_ADDR_W      = 3;

	localparam logic [CFG_W-1:0] MAX_UNITS_RST = 6'd16;
	localparam logic             REG_MAX_UNITS = 1'b0;

	typedef enum logic [OP_W-1:0] {
		OP_RES_GLOBAL = 3'd0,
		OP_RES_LAYER  = 3'd1,
		OP_REL_GLOBAL = 3'd2,
		OP_REL_LAYER  = 3'd3,
		OP_OFF_LIMITS = 3'd4
	} op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic exec;
	} cmd_t;

endpackage

FILE: hdl/sua_ctrl.sv
`timescale 1ns / 1ps

module sua_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          out_ready,
	output logic          out_valid,
	output sua_pkg::cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   fire;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// A word may be executed once the output register is empty or being drained.
	assign fire = (state_q == ST_EXEC) && (!out_valid_q || out_ready);

	assign cmd.capture = in_valid && in_ready;
	assign cmd.exec    = fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hdl/sua_datapath.sv
`timescale 1ns / 1ps
`include "scoped_unit_allocator_top_defines.svh"

module sua_datapath #(
	parameter int MAX_UNITS  = sua_pkg::MAX_UNITS_DEF,
	parameter int MAX_LAYERS = sua_pkg::MAX_LAYERS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sua_pkg::cmd_t               cmd,
	input  logic [sua_pkg::CFG_W-1:0]   max_units,
	input  logic [sua_pkg::OP_W-1:0]    operation,
	input  logic [sua_pkg::SLOT_W-1:0]  layer_slot,
	input  logic [sua_pkg::UNIT_W-1:0]  unit_index,
	output logic                        ok,
	output logic [sua_pkg::UNIT_W-1:0]  granted_unit
);

	localparam int MAP_BITS = sua_pkg::MAP_BITS;
	localparam int POOL_CAP = (MAX_UNITS < MAP_BITS) ? MAX_UNITS : MAP_BITS;
	localparam int LAYER_W  = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;

	// Captured word.
	sua_pkg::op_t                 op_q;
	logic [sua_pkg::SLOT_W-1:0]   slot_q;
	logic [sua_pkg::UNIT_W-1:0]   unit_in_q;

	// Allocation state.
	logic [MAP_BITS-1:0]          global_q;
	logic [MAP_BITS-1:0]          layer_q [MAX_LAYERS];
	logic [MAP_BITS-1:0]          union_q;

	// Result register.
	logic                         ok_q;
	logic [sua_pkg::UNIT_W-1:0]   unit_q;

	logic                         slot_ok;
	logic [LAYER_W-1:0]           slot_idx;
	logic [MAP_BITS-1:0]          sel_map;
	logic [MAP_BITS-1:0]          union_next;
	logic [sua_pkg::CFG_W-1:0]    lim;
	logic [MAP_BITS-1:0]          lim_mask;
	logic [MAP_BITS-1:0]          taken;
	logic [MAP_BITS-1:0]          free_map;
	logic                         found;
	logic [sua_pkg::UNIT_W-1:0]   found_unit;
	logic [MAP_BITS-1:0]          unit_bit;
	logic [MAP_BITS-1:0]          grant_bit;
	logic                         res_ok;
	logic [sua_pkg::UNIT_W-1:0]   res_unit;

	assign ok           = ok_q;
	assign granted_unit = unit_q;

	assign slot_ok  = (32'(slot_q) < MAX_LAYERS);
	assign slot_idx = LAYER_W'(slot_q);
	assign sel_map  = layer_q[slot_idx];
	assign unit_bit = MAP_BITS'(1) << unit_in_q;

	assign lim = (max_units > sua_pkg::CFG_W'(POOL_CAP)) ? sua_pkg::CFG_W'(POOL_CAP)
		: max_units;

	always_comb begin
		union_next = '0;
		for (int i = 0; i < MAX_LAYERS; i++) begin
			union_next = union_next | layer_q[i];
		end
	end

	always_comb begin
		for (int i = 0; i < MAP_BITS; i++) begin
			lim_mask[i] = (sua_pkg::CFG_W'(i) < lim);
		end
	end

	assign taken    = (op_q == sua_pkg::OP_RES_LAYER) ? (global_q | sel_map)
		: (global_q | union_q);
	assign free_map = ~taken & lim_mask;

	// Lowest free unit wins.
	always_comb begin
		found      = 1'b0;
		found_unit = '0;
		for (int i = MAP_BITS - 1; i >= 0; i--) begin
			if (free_map[i]) begin
				found      = 1'b1;
				found_unit = sua_pkg::UNIT_W'(i);
			end
		end
	end

	assign grant_bit = MAP_BITS'(1) << found_unit;

	always_comb begin
		res_ok   = 1'b0;
		res_unit = '0;
		case (op_q)
			sua_pkg::OP_RES_GLOBAL: begin
				res_ok   = found;
				res_unit = found ? found_unit : '0;
			end
			sua_pkg::OP_RES_LAYER: begin
				res_ok   = found && slot_ok;
				res_unit = (found && slot_ok) ? found_unit : '0;
			end
			sua_pkg::OP_REL_GLOBAL: begin
				res_ok = 1'b1;
			end
			sua_pkg::OP_REL_LAYER: begin
				res_ok = 1'b1;
			end
			sua_pkg::OP_OFF_LIMITS: begin
				res_ok = ((global_q | union_q) & unit_bit) == '0;
			end
			default: begin
				res_ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= sua_pkg::op_t'(operation);
			slot_q    <= layer_slot;
			unit_in_q <= unit_index;
		end
		if (cmd.exec) begin
			ok_q   <= res_ok;
			unit_q <= res_unit;
		end
	end

	// The registered union of all layer maps follows the maps in the cycle after they change; the idle cycle
	// between two executions lets it settle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			global_q <= '0;
			union_q  <= '0;
			for (int i = 0; i < MAX_LAYERS; i++) begin
				layer_q[i] <= '0;
			end
		end else begin
			union_q <= union_next;
			if (cmd.exec) begin
				case (op_q)
					sua_pkg::OP_RES_GLOBAL: begin
						if (res_ok) begin
							global_q <= global_q | grant_bit;
						end
					end
					sua_pkg::OP_RES_LAYER: begin
						if (res_ok) begin
							layer_q[slot_idx] <= sel_map | grant_bit;
						end
					end
					sua_pkg::OP_REL_GLOBAL: begin
						global_q <= global_q & ~unit_bit;
					end
					sua_pkg::OP_REL_LAYER: begin
						if (slot_ok) begin
							layer_q[slot_idx] <= sel_map & ~unit_bit;
						end
					end
					sua_pkg::OP_OFF_LIMITS: begin
						if (res_ok) begin
							global_q <= global_q | unit_bit;
						end
					end
					default: begin
						global_q <= global_q;
					end
				endcase
			end
		end
	end

	`SUA_ASSERT_NOW(a_fail_grants_zero, clk, arst_n, cmd.exec && !res_ok, res_unit == '0)
	`SUA_ASSERT_NOW(a_grant_in_pool, clk, arst_n, cmd.exec && res_ok && (op_q == sua_pkg::OP_RES_GLOBAL || op_q == sua_pkg::OP_RES_LAYER), sua_pkg::CFG_W'(res_unit) < lim)
	`SUA_ASSERT_NEXT(a_global_grant_marked, clk, arst_n, cmd.exec && res_ok && op_q == sua_pkg::OP_RES_GLOBAL, global_q[$past(res_unit)])
	`SUA_ASSERT_NEXT(a_union_tracks_maps, clk, arst_n, cmd.exec, !cmd.exec)

endmodule

FILE: hdl/scoped_unit_allocator_top.sv
// A word is accepted only in the idle state, executes in the exec state once the
// result register is free and has its result registered. A new word is accepted
// only after the last executed, letting the registered union follow each update.
// The result register lets the next word be accepted while a result waits.
// Reset (arst_n low, asynchronous) clears all maps, sets max_units to 16 and
// empties the result register.
`timescale 1ns / 1ps

module scoped_unit_allocator_top #(
	parameter int MAX_UNITS  = sua_pkg::MAX_UNITS_DEF,
	parameter int MAX_LAYERS = sua_pkg::MAX_LAYERS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sua_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [sua_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [sua_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [sua_pkg::OP_W-1:0]        operation,
	input  logic [sua_pkg::SLOT_W-1:0]      layer_slot,
	input  logic [sua_pkg::UNIT_W-1:0]      unit_index,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            ok,
	output logic [sua_pkg::UNIT_W-1:0]      granted_unit
);

	logic [sua_pkg::CFG_W-1:0] max_units_q;
	logic                      reg_sel;
	sua_pkg::cmd_t             cmd;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[sua_pkg::APB_ADDR_W-1] == sua_pkg::REG_MAX_UNITS);
	assign prdata  = reg_sel ? sua_pkg::APB_DATA_W'(max_units_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_units_q <= sua_pkg::MAX_UNITS_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			max_units_q <= pwdata[sua_pkg::CFG_W-1:0];
		end
	end

	sua_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	sua_datapath #(
		.MAX_UNITS  (MAX_UNITS),
		.MAX_LAYERS (MAX_LAYERS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.max_units    (max_units_q),
		.operation    (operation),
		.layer_slot   (layer_slot),
		.unit_index   (unit_index),
		.ok           (ok),
		.granted_unit (granted_unit)
	);

endmodule
